// File: hdl/s1re_pkg.sv
// ---------------------------------------------------------------------------
// s1re_pkg
// Shared types, constants and helpers for the S19 record encoder.
// ---------------------------------------------------------------------------
package s1re_pkg;

    localparam int REC_BYTES = 32;
    localparam int IDX_W     = $clog2(REC_BYTES);
    localparam int FILL_W    = $clog2(REC_BYTES + 1);
    localparam int ADDR_W    = 16;
    localparam int RADDR_W   = ADDR_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ADDR   = 2'd1;

    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] S9_LEN     = 8'h03;
    localparam logic [7:0] S9_SUM     = 8'hFC;
    localparam logic [7:0] REC_OVHD   = 8'h03;
    localparam logic [1:0] CNT_ONE    = 2'd1;
    localparam logic [1:0] CNT_TWO    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S1,
        ST_LEN,
        ST_HI,
        ST_LO,
        ST_DATA,
        ST_SUM,
        ST_NL,
        ST_S9,
        ST_S9_LEN,
        ST_S9_HI,
        ST_S9_LO,
        ST_S9_SUM,
        ST_S9_NL
    } state_t;

    typedef struct packed {
        logic   accept;   // request taken this cycle
        logic   emit;     // load output register with a pair
        logic   last;     // pair closes the run
        state_t kind;     // which pair to build
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_rec;   // request would close a record
        logic eod;        // request carries end of data
        logic out_full;   // output register occupied
        logic last_data;  // data index on final buffered byte
    } dp_status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = 8'h30 + {4'd0, nib};
        else
            c = 8'h37 + {4'd0, nib};
        return c;
    endfunction

endpackage

// File: hdl/s1_record_encoder.sv
// ---------------------------------------------------------------------------
// s1_record_encoder
// Streaming Motorola S19 encoder: bytes in, S1/S9 text pairs out.
// ---------------------------------------------------------------------------
// Output: the first pair of a run passes through the state register and then the output pair register.
// Flow: a request that only buffers a byte leaves the sequencer idle; one that
//   closes a record holds the input for 6 + bytes pairs (up to 38 pairs),
//   plus 6 for an S9 trailer, paced by the single output register.
// Reset: async, active low; start 0x0000, end 0xFFFF, empty record buffer.
// ---------------------------------------------------------------------------
module s1_record_encoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [s1re_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [s1re_pkg::ADDR_W-1:0]           cfg_wr_data,
    // input request channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            data_byte,
    input  logic                                  byte_present,
    input  logic                                  end_of_data,
    // output request channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [7:0]                            first_char,
    output logic [7:0]                            second_char,
    output logic [1:0]                            char_count,
    output logic                                  last_of_run
);
    import s1re_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer: idle takes requests; each other state sends one pair when
    // the output register is free or being drained.
    s1re_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: 32-byte buffer (registered read), address/fill tracking,
    // running checksum and the output pair register.
    s1re_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .end_of_data  (end_of_data),
        .out_ready    (out_ready),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .first_char   (first_char),
        .second_char  (second_char),
        .char_count   (char_count),
        .last_of_run  (last_of_run)
    );

endmodule

// File: hdl/s1re_ctrl.sv
// ---------------------------------------------------------------------------
// s1re_ctrl
// Sequencer: walks the S1 and S9 record fields one output pair at a time.
// ---------------------------------------------------------------------------
module s1re_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_ready,
    input  s1re_pkg::dp_status_t status,
    output s1re_pkg::ctrl_cmd_t  cmd
);
    import s1re_pkg::*;

    state_t state_reg, state_next;
    logic   eod_pend_reg, eod_pend_next;
    logic   emit_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            eod_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            eod_pend_reg <= eod_pend_next;
        end
    end

    assign emit_ok  = !status.out_full || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        eod_pend_next = eod_pend_reg;
        cmd.accept    = 1'b0;
        cmd.emit      = 1'b0;
        cmd.last      = 1'b0;
        cmd.kind      = state_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept    = 1'b1;
                    eod_pend_next = status.eod;
                    if (status.need_rec)
                        state_next = ST_S1;
                    else if (status.eod)
                        state_next = ST_S9;
                end
            end
            ST_S1, ST_LEN, ST_HI, ST_LO, ST_DATA, ST_SUM, ST_NL,
            ST_S9, ST_S9_LEN, ST_S9_HI, ST_S9_LO, ST_S9_SUM, ST_S9_NL:
            begin
                if (emit_ok)
                begin
                    cmd.emit = 1'b1;
                    unique case (state_reg)
                        ST_S1:     state_next = ST_LEN;
                        ST_LEN:    state_next = ST_HI;
                        ST_HI:     state_next = ST_LO;
                        ST_LO:     state_next = ST_DATA;
                        ST_DATA:   state_next = status.last_data ? ST_SUM : ST_DATA;
                        ST_SUM:    state_next = ST_NL;
                        ST_NL:
                        begin
                            cmd.last   = !eod_pend_reg;
                            state_next = eod_pend_reg ? ST_S9 : ST_IDLE;
                        end
                        ST_S9:     state_next = ST_S9_LEN;
                        ST_S9_LEN: state_next = ST_S9_HI;
                        ST_S9_HI:  state_next = ST_S9_LO;
                        ST_S9_LO:  state_next = ST_S9_SUM;
                        ST_S9_SUM: state_next = ST_S9_NL;
                        default:
                        begin
                            cmd.last      = 1'b1;
                            eod_pend_next = 1'b0;
                            state_next    = ST_IDLE;
                        end
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: hdl/s1re_datapath.sv
// ---------------------------------------------------------------------------
// s1re_datapath
// Record buffer, address and fill tracking, checksum and output register.
// ---------------------------------------------------------------------------
module s1re_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [s1re_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [s1re_pkg::ADDR_W-1:0]           cfg_wr_data,
    input  logic [7:0]                            data_byte,
    input  logic                                  byte_present,
    input  logic                                  end_of_data,
    input  logic                                  out_ready,
    input  s1re_pkg::ctrl_cmd_t                   cmd,
    output s1re_pkg::dp_status_t                  status,
    output logic                                  out_valid,
    output logic [7:0]                            first_char,
    output logic [7:0]                            second_char,
    output logic [1:0]                            char_count,
    output logic                                  last_of_run
);
    import s1re_pkg::*;

    logic [7:0]         mem [REC_BYTES];
    logic [7:0]         rd_data_reg;

    logic [ADDR_W-1:0]  start_reg, end_reg;
    logic [RADDR_W-1:0] raddr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               limit_reg;
    logic [FILL_W-1:0]  idx_reg, idx_next;
    logic [7:0]         sum_reg;
    logic               out_valid_reg;
    logic [7:0]         c1_reg, c2_reg;
    logic [1:0]         cnt_reg;
    logic               last_reg;

    logic [RADDR_W:0]   byte_addr;
    logic               store, close_rec;
    logic [FILL_W-1:0]  fill_inc;
    logic [7:0]         len;
    logic [7:0]         c1, c2;
    logic [1:0]         cnt;
    logic               rec_done, image_done;

    assign byte_addr = {1'b0, raddr_reg} + {{(RADDR_W + 1 - FILL_W){1'b0}}, fill_reg};
    assign fill_inc  = fill_reg + 1'b1;
    assign store     = byte_present && !limit_reg
                       && (byte_addr <= {{(RADDR_W + 1 - ADDR_W){1'b0}}, end_reg})
                       && (fill_reg < FILL_W'(REC_BYTES));
    assign close_rec = store && ((byte_addr == {{(RADDR_W + 1 - ADDR_W){1'b0}}, end_reg})
                       || (fill_inc >= FILL_W'(REC_BYTES)));

    assign status.need_rec  = close_rec || (end_of_data && (store || fill_reg != '0));
    assign status.eod       = end_of_data;
    assign status.out_full  = out_valid_reg;
    assign status.last_data = (idx_reg == fill_reg - 1'b1);

    assign len        = {{(8 - FILL_W){1'b0}}, fill_reg} + REC_OVHD;
    assign rec_done   = cmd.emit && (cmd.kind == ST_NL);
    assign image_done = cmd.emit && (cmd.kind == ST_S9_NL);

    // data index runs only while data pairs go out
    always_comb
    begin
        if (cmd.kind != ST_DATA)
            idx_next = '0;
        else if (cmd.emit)
            idx_next = idx_reg + 1'b1;
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && store)
            mem[fill_reg[IDX_W-1:0]] <= data_byte;
        rd_data_reg <= mem[idx_next[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '1;
            raddr_reg <= '0;
            fill_reg  <= '0;
            limit_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.accept && store)
            begin
                fill_reg <= fill_inc;
                if (byte_addr == {{(RADDR_W + 1 - ADDR_W){1'b0}}, end_reg})
                    limit_reg <= 1'b1;
            end
            if (rec_done)
            begin
                raddr_reg <= raddr_reg + {{(RADDR_W - FILL_W){1'b0}}, fill_reg};
                fill_reg  <= '0;
            end
            if (image_done)
            begin
                raddr_reg <= {1'b0, start_reg};
                fill_reg  <= '0;
                limit_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_START_ADDR)
                begin
                    start_reg <= cfg_wr_data;
                    raddr_reg <= {1'b0, cfg_wr_data};
                    fill_reg  <= '0;
                    limit_reg <= 1'b0;
                end
                else if (cfg_index == CFG_END_ADDR)
                begin
                    end_reg   <= cfg_wr_data;
                    raddr_reg <= {1'b0, start_reg};
                    fill_reg  <= '0;
                    limit_reg <= 1'b0;
                end
            end
        end
    end

    // checksum: seeded from length and address, then data subtracted
    always_ff @(posedge clk)
    begin
        if (cmd.emit && cmd.kind == ST_LO)
            sum_reg <= 8'hFF - len - raddr_reg[15:8] - raddr_reg[7:0];
        else if (cmd.emit && cmd.kind == ST_DATA)
            sum_reg <= sum_reg - rd_data_reg;
    end

    always_comb
    begin
        cnt = CNT_TWO;
        unique case (cmd.kind)
            ST_S1:     begin c1 = CHAR_S; c2 = CHAR_ONE; end
            ST_LEN:    begin c1 = hex_char(len[7:4]); c2 = hex_char(len[3:0]); end
            ST_HI:
            begin
                c1 = hex_char(raddr_reg[15:12]);
                c2 = hex_char(raddr_reg[11:8]);
            end
            ST_LO:
            begin
                c1 = hex_char(raddr_reg[7:4]);
                c2 = hex_char(raddr_reg[3:0]);
            end
            ST_DATA:
            begin
                c1 = hex_char(rd_data_reg[7:4]);
                c2 = hex_char(rd_data_reg[3:0]);
            end
            ST_SUM:
            begin
                c1 = hex_char(sum_reg[7:4]);
                c2 = hex_char(sum_reg[3:0]);
            end
            ST_S9:     begin c1 = CHAR_S; c2 = CHAR_NINE; end
            ST_S9_LEN: begin c1 = hex_char(S9_LEN[7:4]); c2 = hex_char(S9_LEN[3:0]); end
            ST_S9_HI, ST_S9_LO:
            begin
                c1 = hex_char(4'd0);
                c2 = hex_char(4'd0);
            end
            ST_S9_SUM: begin c1 = hex_char(S9_SUM[7:4]); c2 = hex_char(S9_SUM[3:0]); end
            ST_NL, ST_S9_NL:
            begin
                c1  = CHAR_LF;
                c2  = 8'h00;
                cnt = CNT_ONE;
            end
            default:   begin c1 = 8'h00; c2 = 8'h00; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            c1_reg   <= c1;
            c2_reg   <= c2;
            cnt_reg  <= cnt;
            last_reg <= cmd.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign first_char  = c1_reg;
    assign second_char = c2_reg;
    assign char_count  = cnt_reg;
    assign last_of_run = last_reg;

endmodule

// File: hdl/s1re_checker.sv
// ---------------------------------------------------------------------------
// s1re_checker
// Port-level checks on the encoder output stream, bound to the top level.
// ---------------------------------------------------------------------------
module s1re_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] first_char,
    input logic [7:0] second_char,
    input logic [1:0] char_count,
    input logic       last_of_run
);
    import s1re_pkg::*;

    // stalled output request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_char)
            && $stable(second_char) && $stable(char_count) && $stable(last_of_run))
        else $error("output request changed while stalled");

    // single-character result is always a bare newline
    a_newline: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_count == CNT_ONE |-> first_char == CHAR_LF && second_char == 8'h00)
        else $error("single character result is not a newline");

    // every run ends on a newline
    a_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_run |-> char_count == CNT_ONE)
        else $error("run ended on a non-newline result");

    // no new request while a run is still being sent
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !in_ready)
        else $error("input ready during an unfinished run");

endmodule

bind s1_record_encoder s1re_checker u_s1re_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .first_char  (first_char),
    .second_char (second_char),
    .char_count  (char_count),
    .last_of_run (last_of_run)
);
